/* design/rme_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Rendezvous message engine package
// Shared codes and default sizes for the message engine.
// ----------------------------------------------------------------------------
package rme_pkg;

  localparam int TASK_COUNT_DEF = 16;
  localparam int BODY_BITS_DEF  = 32;

  typedef enum logic [1:0] {
    ACT_SEND = 2'd0,
    ACT_RECV = 2'd1,
    ACT_IRQ  = 2'd2,
    ACT_BAD  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_NAMED = 2'd0,
    KIND_ANY   = 2'd1,
    KIND_IRQ   = 2'd2,
    KIND_BAD   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_SEND = 2'd1,
    MODE_RECV = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    AW_NONE = 2'd0,
    AW_TASK = 2'd1,
    AW_ANY  = 2'd2,
    AW_IRQ  = 2'd3
  } await_t;

  typedef enum logic [3:0] {
    ST_HANDED    = 4'd0,
    ST_QUEUED    = 4'd1,
    ST_TAKEN     = 4'd2,
    ST_BLOCKED   = 4'd3,
    ST_IRQ_DELIV = 4'd4,
    ST_IRQ_PEND  = 4'd5,
    ST_DEADLOCK  = 4'd6,
    ST_BUSY      = 4'd7,
    ST_BAD       = 4'd8
  } status_t;

endpackage : rme_pkg
`default_nettype wire

/* design/rme_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : rme_ram
`default_nettype wire

/* design/rendezvous_message_engine_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Rendezvous message engine
// Blocking send/receive between tasks; per-task records and queue heads sit
// in two RAMs and are read, modified and written back by one sequencer.
// Items rejected up front finish in the idle state; a chain walk (deadlock
//   walk and queue walk) reads task memory up to TASK_COUNT times.
// Throughput: one transaction at a time; busy holds off start until done.
// Reset: a clearing pass empties every task record and queue head, busy high.
// Results show for one cycle on done; the receiver cannot stall.
// ----------------------------------------------------------------------------
module rendezvous_message_engine_core #(
  parameter int TASK_COUNT = rme_pkg::TASK_COUNT_DEF,
  parameter int BODY_BITS  = rme_pkg::BODY_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  action,
  input  wire logic [3:0]  caller,
  input  wire logic [3:0]  peer,
  input  wire logic [1:0]  peer_kind,
  input  wire logic [31:0] payload,
  output logic             done,
  output logic [3:0]       status,
  output logic             woken_valid,
  output logic [3:0]       woken_task,
  output logic [3:0]       delivered_to,
  output logic [3:0]       msg_source,
  output logic             from_interrupt,
  output logic [31:0]      msg_body
);

  import rme_pkg::*;

  localparam int TW = $clog2(TASK_COUNT);

  typedef logic [TW-1:0] idx_t;

  typedef struct packed {
    logic [BODY_BITS-1:0] body;
    logic                 nxt_nil;
    idx_t                 nxt;
    logic                 irq;
    await_t               aw_kind;
    idx_t                 aw_idx;
    idx_t                 tgt;
    mode_t                mode;
  } rec_t;

  typedef struct packed {
    logic nil;
    idx_t idx;
  } head_t;

  typedef struct packed {
    status_t              status;
    logic                 wv;
    logic [3:0]           wt;
    logic [3:0]           dt;
    logic [3:0]           src;
    logic                 irq;
    logic [BODY_BITS-1:0] body;
  } res_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WAIT, S_CALLER, S_DL, S_ENQ, S_ENQ_WALK,
    S_NAMED, S_TAKE, S_UNL_WALK, S_FIN
  } state_t;

  localparam idx_t LAST = TW'(TASK_COUNT - 1);

  function automatic res_t mk(status_t s, logic wv, idx_t wt, idx_t dt, idx_t src,
                              logic fi, logic [BODY_BITS-1:0] b);
    res_t r;
    r.status = s;
    r.wv     = wv;
    r.wt     = 4'(wt);
    r.dt     = 4'(dt);
    r.src    = 4'(src);
    r.irq    = fi;
    r.body   = b;
    return r;
  endfunction

  function automatic rec_t rst_rec();
    rec_t r;
    r = '0;
    r.mode    = MODE_IDLE;
    r.aw_kind = AW_NONE;
    r.nxt_nil = 1'b1;
    return r;
  endfunction

  state_t               state;
  state_t               ret_st;
  idx_t                 ptr;
  idx_t                 bptr;
  idx_t                 step;
  idx_t                 clr;
  idx_t                 cal;
  idx_t                 per;
  idx_t                 from;
  logic [1:0]           act;
  logic [1:0]           knd;
  logic [BODY_BITS-1:0] bdy;
  rec_t                 cr;
  rec_t                 pr;
  rec_t                 fr;
  head_t                hd;
  res_t                 res;

  logic                 a_we;
  idx_t                 a_wa;
  rec_t                 a_wd;
  rec_t                 a_rdata;
  logic                 b_we;
  idx_t                 b_wa;
  head_t                b_wd;
  head_t                b_rdata;

  rec_t                 prv;
  rec_t                 blk;
  rec_t                 ra;

  rme_ram #(.WIDTH($bits(rec_t)), .DEPTH(TASK_COUNT)) u_task_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_wa),
    .wdata (a_wd),
    .raddr (ptr),
    .rdata (a_rdata)
  );

  rme_ram #(.WIDTH($bits(head_t)), .DEPTH(TASK_COUNT)) u_head_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_wa),
    .wdata (b_wd),
    .raddr (bptr),
    .rdata (b_rdata)
  );

  assign ra  = a_rdata;
  assign prv = (step == '0) ? a_rdata : pr;

  always_comb begin
    blk      = (state == S_CALLER) ? a_rdata : cr;
    blk.mode = MODE_RECV;
    blk.aw_idx = per;
    case (knd)
      KIND_NAMED: blk.aw_kind = AW_TASK;
      KIND_ANY:   blk.aw_kind = AW_ANY;
      default:    blk.aw_kind = AW_IRQ;
    endcase
  end

  assign busy           = (state != S_IDLE);
  assign status         = res.status;
  assign woken_valid    = res.wv;
  assign woken_task     = res.wt;
  assign delivered_to   = res.dt;
  assign msg_source     = res.src;
  assign from_interrupt = res.irq;
  assign msg_body       = 32'(res.body);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    a_we <= 1'b0;
    b_we <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      ptr   <= '0;
      bptr  <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          a_we <= 1'b1;
          a_wa <= clr;
          a_wd <= rst_rec();
          b_we <= 1'b1;
          b_wa <= clr;
          b_wd <= '{nil: 1'b1, idx: '0};
          if (clr == LAST) begin
            state <= S_IDLE;
          end else begin
            clr <= clr + 1'b1;
          end
        end

        S_IDLE: begin
          if (start) begin
            act <= action;
            knd <= peer_kind;
            cal <= TW'(caller);
            per <= TW'(peer);
            bdy <= BODY_BITS'(payload);
            if (action == ACT_BAD) begin
              res <= mk(ST_BAD, 1'b0, '0, '0, '0, 1'b0, '0);
              done <= 1'b1;
            end else if (32'(caller) >= 32'(TASK_COUNT)) begin
              res <= mk(ST_BUSY, 1'b0, '0, '0, '0, 1'b0, '0);
              done <= 1'b1;
            end else if (action == ACT_SEND &&
                         (32'(peer) >= 32'(TASK_COUNT) || peer == caller)) begin
              res <= mk(ST_BUSY, 1'b0, '0, '0, '0, 1'b0, '0);
              done <= 1'b1;
            end else if (action == ACT_RECV && peer_kind == KIND_BAD) begin
              res <= mk(ST_BAD, 1'b0, '0, '0, '0, 1'b0, '0);
              done <= 1'b1;
            end else if (action == ACT_RECV && peer_kind == KIND_NAMED &&
                         (32'(peer) >= 32'(TASK_COUNT) || peer == caller)) begin
              res <= mk(ST_BUSY, 1'b0, '0, '0, '0, 1'b0, '0);
              done <= 1'b1;
            end else begin
              ptr    <= TW'(caller);
              bptr   <= TW'(caller);
              ret_st <= S_CALLER;
              state  <= S_WAIT;
            end
          end
        end

        S_WAIT: begin
          state <= ret_st;
        end

        S_CALLER: begin
          cr <= ra;
          hd <= b_rdata;
          a_wa <= cal;
          state <= S_IDLE;
          if (act == ACT_IRQ) begin
            a_we <= 1'b1;
            done <= 1'b1;
            if (ra.mode == MODE_RECV && (ra.aw_kind == AW_ANY || ra.aw_kind == AW_IRQ)) begin
              a_wd         <= ra;
              a_wd.mode    <= MODE_IDLE;
              a_wd.aw_kind <= AW_NONE;
              a_wd.irq     <= 1'b0;
              res <= mk(ST_IRQ_DELIV, 1'b1, cal, cal, '0, 1'b1, '0);
            end else begin
              a_wd     <= ra;
              a_wd.irq <= 1'b1;
              res <= mk(ST_IRQ_PEND, 1'b0, '0, '0, '0, 1'b0, '0);
            end
          end else if (ra.mode != MODE_IDLE) begin
            res  <= mk(ST_BUSY, 1'b0, '0, '0, '0, 1'b0, '0);
            done <= 1'b1;
          end else if (act == ACT_SEND) begin
            ptr    <= per;
            step   <= '0;
            ret_st <= S_DL;
            state  <= S_WAIT;
          end else if (ra.irq && knd != KIND_NAMED) begin
            a_we     <= 1'b1;
            a_wd     <= ra;
            a_wd.irq <= 1'b0;
            res  <= mk(ST_IRQ_DELIV, 1'b0, '0, cal, '0, 1'b1, '0);
            done <= 1'b1;
          end else if (knd == KIND_ANY && !b_rdata.nil) begin
            from   <= b_rdata.idx;
            ptr    <= b_rdata.idx;
            ret_st <= S_TAKE;
            state  <= S_WAIT;
          end else if (knd == KIND_NAMED) begin
            ptr    <= per;
            ret_st <= S_NAMED;
            state  <= S_WAIT;
          end else begin
            a_we <= 1'b1;
            a_wd <= blk;
            res  <= mk(ST_BLOCKED, 1'b0, '0, '0, '0, 1'b0, '0);
            done <= 1'b1;
          end
        end

        S_DL: begin
          if (step == '0) begin
            pr <= ra;
          end
          if (ra.mode == MODE_SEND && ra.tgt == cal) begin
            res   <= mk(ST_DEADLOCK, 1'b0, '0, '0, '0, 1'b0, '0);
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (ra.mode == MODE_SEND && step != LAST) begin
            ptr   <= ra.tgt;
            step  <= step + 1'b1;
            state <= S_WAIT;
          end else if (prv.mode == MODE_RECV &&
                       ((prv.aw_kind == AW_TASK && prv.aw_idx == cal) ||
                        prv.aw_kind == AW_ANY)) begin
            a_we         <= 1'b1;
            a_wa         <= per;
            a_wd         <= prv;
            a_wd.mode    <= MODE_IDLE;
            a_wd.aw_kind <= AW_NONE;
            res   <= mk(ST_HANDED, 1'b1, per, per, cal, 1'b0, bdy);
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            a_we         <= 1'b1;
            a_wa         <= cal;
            a_wd         <= cr;
            a_wd.mode    <= MODE_SEND;
            a_wd.tgt     <= per;
            a_wd.body    <= bdy;
            a_wd.nxt_nil <= 1'b1;
            bptr   <= per;
            ret_st <= S_ENQ;
            state  <= S_WAIT;
          end
        end

        S_ENQ: begin
          if (b_rdata.nil) begin
            b_we  <= 1'b1;
            b_wa  <= per;
            b_wd  <= '{nil: 1'b0, idx: cal};
            res   <= mk(ST_QUEUED, 1'b0, '0, '0, '0, 1'b0, '0);
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            ptr    <= b_rdata.idx;
            step   <= '0;
            ret_st <= S_ENQ_WALK;
            state  <= S_WAIT;
          end
        end

        S_ENQ_WALK: begin
          if (ra.nxt_nil || step == LAST) begin
            a_we         <= 1'b1;
            a_wa         <= ptr;
            a_wd         <= ra;
            a_wd.nxt_nil <= 1'b0;
            a_wd.nxt     <= cal;
            res   <= mk(ST_QUEUED, 1'b0, '0, '0, '0, 1'b0, '0);
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            ptr   <= ra.nxt;
            step  <= step + 1'b1;
            state <= S_WAIT;
          end
        end

        S_NAMED, S_TAKE: begin
          if (state == S_NAMED && !(ra.mode == MODE_SEND && ra.tgt == cal)) begin
            a_we  <= 1'b1;
            a_wa  <= cal;
            a_wd  <= blk;
            res   <= mk(ST_BLOCKED, 1'b0, '0, '0, '0, 1'b0, '0);
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            fr <= ra;
            if (state == S_NAMED) begin
              from <= per;
            end
            if (!hd.nil && hd.idx == ((state == S_NAMED) ? per : from)) begin
              b_we  <= 1'b1;
              b_wa  <= cal;
              b_wd  <= '{nil: ra.nxt_nil, idx: ra.nxt};
              state <= S_FIN;
            end else if (hd.nil) begin
              state <= S_FIN;
            end else begin
              ptr    <= hd.idx;
              step   <= '0;
              ret_st <= S_UNL_WALK;
              state  <= S_WAIT;
            end
          end
        end

        S_UNL_WALK: begin
          if (!ra.nxt_nil && ra.nxt == from) begin
            a_we         <= 1'b1;
            a_wa         <= ptr;
            a_wd         <= ra;
            a_wd.nxt_nil <= fr.nxt_nil;
            a_wd.nxt     <= fr.nxt;
            state <= S_FIN;
          end else if (ra.nxt_nil || step == LAST) begin
            state <= S_FIN;
          end else begin
            ptr   <= ra.nxt;
            step  <= step + 1'b1;
            state <= S_WAIT;
          end
        end

        S_FIN: begin
          a_we         <= 1'b1;
          a_wa         <= from;
          a_wd         <= fr;
          a_wd.nxt_nil <= 1'b1;
          a_wd.mode    <= MODE_IDLE;
          a_wd.tgt     <= '0;
          res   <= mk(ST_TAKEN, 1'b1, from, cal, from, 1'b0, fr.body);
          done  <= 1'b1;
          state <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule : rendezvous_message_engine_core
`default_nettype wire

/* verif/rme_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rendezvous message engine checker
// Watches the command and result channels, predicts each result from a
// private copy of the task records and compares it field by field.
// ----------------------------------------------------------------------------
module rme_checker
  import rme_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  action,
  input  wire logic [3:0]  caller,
  input  wire logic [3:0]  peer,
  input  wire logic [1:0]  peer_kind,
  input  wire logic [31:0] payload,
  input  wire logic        done,
  input  wire logic [3:0]  status,
  input  wire logic        woken_valid,
  input  wire logic [3:0]  woken_task,
  input  wire logic [3:0]  delivered_to,
  input  wire logic [3:0]  msg_source,
  input  wire logic        from_interrupt,
  input  wire logic [31:0] msg_body,
  output int               fail_count,
  output int               pending_count,
  output int               result_count
);

  localparam int NTASK = 16;
  localparam logic [4:0] NIL = 5'd31;

  typedef struct packed {
    status_t     st;
    logic        wv;
    logic [3:0]  wt;
    logic [3:0]  to;
    logic [3:0]  src;
    logic        irq;
    logic [31:0] body;
  } outcome_t;

  mode_t       mode_q   [NTASK];
  logic [3:0]  target_q [NTASK];
  await_t      aw_kind  [NTASK];
  logic [3:0]  aw_task  [NTASK];
  logic [31:0] parked_q [NTASK];
  logic        irq_q    [NTASK];
  logic [4:0]  head_q   [NTASK];
  logic [4:0]  link_q   [NTASK];

  outcome_t expected_q[$];

  function automatic outcome_t mk(status_t st, logic wv = 0, logic [3:0] wt = 0,
                                  logic [3:0] to = 0, logic [3:0] src = 0,
                                  logic irq = 0, logic [31:0] body = 0);
    outcome_t o;
    o.st = st; o.wv = wv; o.wt = wt; o.to = to; o.src = src; o.irq = irq; o.body = body;
    return o;
  endfunction

  function automatic bit closes_loop(logic [3:0] from, logic [3:0] dst);
    logic [3:0] p;
    p = dst;
    for (int k = 0; k < NTASK; k++) begin
      if (mode_q[p] != MODE_SEND) return 0;
      if (target_q[p] == from) return 1;
      p = target_q[p];
    end
    return 0;
  endfunction

  function automatic void append_sender(logic [3:0] dst, logic [3:0] who);
    logic [4:0] p;
    link_q[who] = NIL;
    p = head_q[dst];
    if (p == NIL) begin
      head_q[dst] = {1'b0, who};
      return;
    end
    for (int k = 0; k < NTASK; k++) begin
      if (link_q[p[3:0]] == NIL) break;
      p = link_q[p[3:0]];
    end
    link_q[p[3:0]] = {1'b0, who};
  endfunction

  function automatic void remove_sender(logic [3:0] rcv, logic [3:0] who);
    logic [4:0] p;
    p = head_q[rcv];
    if (p == {1'b0, who}) begin
      head_q[rcv] = link_q[who];
      link_q[who] = NIL;
      return;
    end
    for (int k = 0; k < NTASK && p != NIL; k++) begin
      if (link_q[p[3:0]] == {1'b0, who}) begin
        link_q[p[3:0]] = link_q[who];
        break;
      end
      p = link_q[p[3:0]];
    end
    link_q[who] = NIL;
  endfunction

  task automatic clear_records();
    for (int i = 0; i < NTASK; i++) begin
      mode_q[i] = MODE_IDLE; target_q[i] = 0; aw_kind[i] = AW_NONE; aw_task[i] = 0;
      parked_q[i] = 0; irq_q[i] = 0; head_q[i] = NIL; link_q[i] = NIL;
    end
  endtask

  function automatic outcome_t predict_transaction(action_t act, logic [3:0] c,
                                                   logic [3:0] p, kind_t kd,
                                                   logic [31:0] body);
    logic [4:0] from;
    outcome_t o;
    if (act == ACT_BAD) return mk(ST_BAD);
    if (act == ACT_IRQ) begin
      if (mode_q[c] == MODE_RECV && (aw_kind[c] == AW_ANY || aw_kind[c] == AW_IRQ)) begin
        mode_q[c] = MODE_IDLE; aw_kind[c] = AW_NONE; irq_q[c] = 0;
        return mk(ST_IRQ_DELIV, 1, c, c, 0, 1, 0);
      end
      irq_q[c] = 1;
      return mk(ST_IRQ_PEND);
    end
    if (act == ACT_SEND) begin
      if (p == c || mode_q[c] != MODE_IDLE) return mk(ST_BUSY);
      if (closes_loop(c, p)) return mk(ST_DEADLOCK);
      if (mode_q[p] == MODE_RECV &&
          ((aw_kind[p] == AW_TASK && aw_task[p] == c) || aw_kind[p] == AW_ANY)) begin
        mode_q[p] = MODE_IDLE; aw_kind[p] = AW_NONE;
        return mk(ST_HANDED, 1, p, p, c, 0, body);
      end
      mode_q[c] = MODE_SEND; target_q[c] = p; parked_q[c] = body;
      append_sender(p, c);
      return mk(ST_QUEUED);
    end
    if (kd == KIND_BAD) return mk(ST_BAD);
    if (mode_q[c] != MODE_IDLE || (kd == KIND_NAMED && p == c)) return mk(ST_BUSY);
    if (irq_q[c] && kd != KIND_NAMED) begin
      irq_q[c] = 0;
      return mk(ST_IRQ_DELIV, 0, 0, c, 0, 1, 0);
    end
    from = NIL;
    if (kd == KIND_ANY) from = head_q[c];
    else if (kd == KIND_NAMED && mode_q[p] == MODE_SEND && target_q[p] == c) from = {1'b0, p};
    if (from != NIL) begin
      o = mk(ST_TAKEN, 1, from[3:0], c, from[3:0], 0, parked_q[from[3:0]]);
      remove_sender(c, from[3:0]);
      mode_q[from[3:0]] = MODE_IDLE; target_q[from[3:0]] = 0;
      return o;
    end
    mode_q[c] = MODE_RECV;
    aw_kind[c] = kd == KIND_NAMED ? AW_TASK : (kd == KIND_ANY ? AW_ANY : AW_IRQ);
    aw_task[c] = p;
    return mk(ST_BLOCKED);
  endfunction

  outcome_t got, want;

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_records();
      expected_q.delete();
      fail_count <= 0;
      result_count <= 0;
      pending_count <= 0;
    end else begin
      if (start && !busy)
        expected_q.push_back(predict_transaction(action_t'(action), caller, peer,
                                                 kind_t'(peer_kind), payload));
      if (done) begin
        result_count <= result_count + 1;
        got = mk(status_t'(status), woken_valid, woken_task, delivered_to, msg_source,
                 from_interrupt, msg_body);
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result: %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("mismatch: exp st=%0d wv=%0d wt=%0d to=%0d src=%0d irq=%0d body=%h",
                       want.st, want.wv, want.wt, want.to, want.src, want.irq, want.body);
              $display("          got st=%0d wv=%0d wt=%0d to=%0d src=%0d irq=%0d body=%h",
                       got.st, got.wv, got.wt, got.to, got.src, got.irq, got.body);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= expected_q.size();
    end
  end

endmodule

/* verif/tb_rendezvous_message_engine_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rendezvous message engine testbench
// Drives directed and random send, receive and interrupt transactions with
// random start gaps; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_rendezvous_message_engine_core;
  import rme_pkg::*;

  localparam int ITEMS = 850;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk, rst, start, busy, done;
  logic [1:0]  action, peer_kind;
  logic [3:0]  caller, peer;
  logic [31:0] payload;
  logic [3:0]  status, woken_task, delivered_to, msg_source;
  logic        woken_valid, from_interrupt;
  logic [31:0] msg_body;
  int          fail_count, pending_count, result_count;
  int          cycle_count;
  bit          no_gaps;

  rendezvous_message_engine_core i_dut (.*);

  rme_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic issue(action_t act, logic [3:0] c, logic [3:0] p, kind_t kd,
                       logic [31:0] body);
    int gap;
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      start <= 0;
      repeat (gap) @(negedge clk);
    end
    action <= act; caller <= c; peer <= p; peer_kind <= kd; payload <= body;
    start <= 1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic random_transaction(int pool);
    int r;
    logic [3:0] c, p;
    r = $urandom_range(0, 99);
    c = 4'($urandom_range(0, pool - 1));
    p = 4'($urandom_range(0, pool - 1));
    if (r < 45) issue(ACT_SEND, c, p, KIND_NAMED, $urandom());
    else if (r < 85) issue(ACT_RECV, c, p, kind_t'($urandom_range(0, 2)), $urandom());
    else if (r < 95) issue(ACT_IRQ, c, p, kind_t'($urandom_range(0, 3)), $urandom());
    else issue(action_t'($urandom_range(0, 3)), 4'($urandom()), 4'($urandom()),
               kind_t'($urandom_range(0, 3)), $urandom());
  endtask

  initial begin
    rst = 1; start = 0; action = 0; caller = 0; peer = 0; peer_kind = 0; payload = 0;
    no_gaps = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;
    issue(ACT_BAD, 4'd3, 4'd0, KIND_NAMED, 32'h0);
    issue(ACT_RECV, 4'd1, 4'd2, KIND_BAD, 32'h0);
    issue(ACT_SEND, 4'd5, 4'd5, KIND_NAMED, 32'h1);
    issue(ACT_RECV, 4'd5, 4'd5, KIND_NAMED, 32'h0);
    issue(ACT_RECV, 4'd0, 4'd15, KIND_NAMED, 32'h0);
    issue(ACT_SEND, 4'd15, 4'd0, KIND_NAMED, 32'hFFFF_FFFF);
    issue(ACT_SEND, 4'd1, 4'd0, KIND_NAMED, 32'hA5A5_5A5A);
    issue(ACT_SEND, 4'd15, 4'd1, KIND_NAMED, 32'h0);
    issue(ACT_SEND, 4'd2, 4'd3, KIND_NAMED, 32'h1234_5678);
    issue(ACT_SEND, 4'd3, 4'd2, KIND_NAMED, 32'h0);
    issue(ACT_SEND, 4'd4, 4'd3, KIND_NAMED, 32'h5555_AAAA);
    issue(ACT_RECV, 4'd3, 4'd0, KIND_ANY, 32'h0);
    issue(ACT_RECV, 4'd3, 4'd4, KIND_NAMED, 32'h0);
    issue(ACT_IRQ, 4'd6, 4'd0, KIND_NAMED, 32'h0);
    issue(ACT_RECV, 4'd6, 4'd0, KIND_IRQ, 32'h0);
    issue(ACT_RECV, 4'd7, 4'd0, KIND_IRQ, 32'h0);
    issue(ACT_IRQ, 4'd7, 4'd0, KIND_NAMED, 32'h0);
    issue(ACT_RECV, 4'd8, 4'd0, KIND_ANY, 32'h0);
    issue(ACT_SEND, 4'd9, 4'd8, KIND_NAMED, 32'hDEAD_BEEF);
    issue(ACT_IRQ, 4'd9, 4'd0, KIND_NAMED, 32'h0);
    issue(ACT_RECV, 4'd9, 4'd0, KIND_NAMED, 32'h0);
    issue(ACT_RECV, 4'd0, 4'd9, KIND_ANY, 32'h0);
    start <= 0;
    @(posedge clk);
    wait (pending_count == 0);
    @(negedge clk);
    for (int i = 0; i < ITEMS; i++) begin
      if (i == ITEMS / 2) begin
        start <= 0;
        @(posedge clk);
        wait (pending_count == 0);
        @(negedge clk);
      end
      no_gaps = i > ITEMS * 9 / 10;
      random_transaction(i % 200 < 100 ? 5 : 16);
    end
    start <= 0;
    @(posedge clk);
    wait (pending_count == 0);
    repeat (120) @(posedge clk);
    $display("covered %0d results over send, receive, interrupt and error transactions",
             result_count);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
